### rtl/point_triangle_distance_macros.svh
// Assertion macros shared by the point/triangle distance RTL.
`ifndef POINT_TRIANGLE_DISTANCE_MACROS_SVH
`define POINT_TRIANGLE_DISTANCE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTD_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define PTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### rtl/ptd_pkg.sv
// Shared constants for the point/triangle distance pipeline.
`timescale 1ns / 1ps
package ptd_pkg;
  // Width of the scaled distance result.
  localparam int OUT_W = 20;
  // Bits of the clamped radicand fed to the square root chain.
  localparam int QB = 2 * OUT_W;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int DIST_SCALE_DEF = 10000;
endpackage

### rtl/point_triangle_distance.sv
// Top level: point-in-triangle test and least scaled distance to the edges.
//
//  channel | handshake          | beat payload
//  in      | in_valid/in_stall  | ax ay bx by_coord cx cy px py
//  out     | out_valid/out_stall| inside_res distance_scaled
//
// One beat enters per cycle while the pipe is not held. The pipe runs
// through the divider cell chain (one quotient bit per cell) and then
// the square root cell chain (one root bit per cell).
// Reset clears only the valid bits. The pipe holds while its last stage is
// full and the output register is full and stalled; bubbles hold as well.
`timescale 1ns / 1ps
`include "point_triangle_distance_macros.svh"
module point_triangle_distance #(
  parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF,
  parameter int DIST_SCALE  = ptd_pkg::DIST_SCALE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [COORD_WIDTH-1:0]   in_ax,
  input  logic signed [COORD_WIDTH-1:0]   in_ay,
  input  logic signed [COORD_WIDTH-1:0]   in_bx,
  input  logic signed [COORD_WIDTH-1:0]   in_by_coord,
  input  logic signed [COORD_WIDTH-1:0]   in_cx,
  input  logic signed [COORD_WIDTH-1:0]   in_cy,
  input  logic signed [COORD_WIDTH-1:0]   in_px,
  input  logic signed [COORD_WIDTH-1:0]   in_py,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_inside_res,
  output logic [ptd_pkg::OUT_W-1:0]       out_distance_scaled
);
  import ptd_pkg::*;

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int LW   = PW + 1;
  localparam int NE   = 3;
  localparam int DIV0 = 9;
  localparam int MINS = DIV0 + QB;
  localparam int PIPE = MINS + OUT_W;

  logic en;
  logic v_r [1:PIPE];
  logic ins_r [4:PIPE];

  // differences against the query point and along the edges
  logic signed [DW-1:0] pax_r, pay_r, pbx_r, pby_r, pcx_r, pcy_r;
  logic signed [DW-1:0] bax_r, bay_r, cax_r, cay_r, cbx_r, cby_r;
  // area cross products
  logic signed [PW-1:0] w1_r, w2_r, b1_r, b2_r, a1_r, a2_r, c1_r, c2_r;
  logic signed [LW-1:0] wc_r, bc_r, ac_r, cc_r;
  logic [LW-1:0]        wm, bm, am, cm;
  logic [LW+1:0]        psum;

  // divider lanes
  logic [QB-1:0] nlo [NE];
  logic [LW-1:0] r0 [NE];
  logic [LW-1:0] dv0 [NE];
  logic          st0 [NE];
  logic [LW-1:0] dr   [NE][QB+1];
  logic [QB-1:0] dnq  [NE][QB+1];
  logic [LW-1:0] ddv  [NE][QB+1];
  logic          dsat [NE][QB+1];
  logic [QB-1:0] qv [NE];
  logic [QB-1:0] qmin, qmin_r;

  // root chain
  logic [QB-1:0]    sx    [OUT_W+1];
  logic [OUT_W+1:0] srem  [OUT_W+1];
  logic [OUT_W-1:0] sroot [OUT_W+1];

  logic                 out_valid_r, out_inside_r;
  logic [OUT_W-1:0]     out_dist_r;

  assign en       = !(v_r[PIPE] && out_valid_r && out_stall);
  assign in_stall = !en;

  // advance the valid and inside sideband
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= PIPE; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int s = 2; s <= PIPE; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins_r[4] <= wm == LW'(psum);
      for (int s = 5; s <= PIPE; s++) ins_r[s] <= ins_r[s-1];
    end
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      pax_r <= DW'(in_px) - DW'(in_ax);
      pay_r <= DW'(in_py) - DW'(in_ay);
      pbx_r <= DW'(in_px) - DW'(in_bx);
      pby_r <= DW'(in_py) - DW'(in_by_coord);
      pcx_r <= DW'(in_px) - DW'(in_cx);
      pcy_r <= DW'(in_py) - DW'(in_cy);
      bax_r <= DW'(in_bx) - DW'(in_ax);
      bay_r <= DW'(in_by_coord) - DW'(in_ay);
      cax_r <= DW'(in_cx) - DW'(in_ax);
      cay_r <= DW'(in_cy) - DW'(in_ay);
      cbx_r <= DW'(in_cx) - DW'(in_bx);
      cby_r <= DW'(in_cy) - DW'(in_by_coord);
    end
  end

  // stages 2-3: doubled areas as cross products
  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= bax_r * cay_r;
      w2_r <= bay_r * cax_r;
      a1_r <= pbx_r * pcy_r;
      a2_r <= pby_r * pcx_r;
      b1_r <= pax_r * pcy_r;
      b2_r <= pay_r * pcx_r;
      c1_r <= pax_r * pby_r;
      c2_r <= pay_r * pbx_r;
      wc_r <= LW'(w1_r) - LW'(w2_r);
      ac_r <= LW'(a1_r) - LW'(a2_r);
      bc_r <= LW'(b1_r) - LW'(b2_r);
      cc_r <= LW'(c1_r) - LW'(c2_r);
    end
  end

  // area equality test
  always_comb begin
    wm   = (wc_r < 0) ? LW'(-wc_r) : LW'(wc_r);
    am   = (ac_r < 0) ? LW'(-ac_r) : LW'(ac_r);
    bm   = (bc_r < 0) ? LW'(-bc_r) : LW'(bc_r);
    cm   = (cc_r < 0) ? LW'(-cc_r) : LW'(cc_r);
    psum = (LW+2)'(am) + (LW+2)'(bm) + (LW+2)'(cm);
    if (psum[LW+1:LW] != 2'b00) psum = '1;
  end

  // edge front ends: AB, AC, BC
  ptd_edge #(.COORD_WIDTH(COORD_WIDTH), .DIST_SCALE(DIST_SCALE)) u_edge_ab (
    .clk(clk), .en(en),
    .ax_i(pax_r), .ay_i(pay_r), .ex_i(bax_r), .ey_i(bay_r), .bx_i(pbx_r), .by_i(pby_r),
    .nlo_o(nlo[0]), .r0_o(r0[0]), .dvs_o(dv0[0]), .sat_o(st0[0])
  );
  ptd_edge #(.COORD_WIDTH(COORD_WIDTH), .DIST_SCALE(DIST_SCALE)) u_edge_ac (
    .clk(clk), .en(en),
    .ax_i(pax_r), .ay_i(pay_r), .ex_i(cax_r), .ey_i(cay_r), .bx_i(pcx_r), .by_i(pcy_r),
    .nlo_o(nlo[1]), .r0_o(r0[1]), .dvs_o(dv0[1]), .sat_o(st0[1])
  );
  ptd_edge #(.COORD_WIDTH(COORD_WIDTH), .DIST_SCALE(DIST_SCALE)) u_edge_bc (
    .clk(clk), .en(en),
    .ax_i(pbx_r), .ay_i(pby_r), .ex_i(cbx_r), .ey_i(cby_r), .bx_i(pcx_r), .by_i(pcy_r),
    .nlo_o(nlo[2]), .r0_o(r0[2]), .dvs_o(dv0[2]), .sat_o(st0[2])
  );

  // divider cell chains, one per edge
  for (genvar e = 0; e < NE; e++) begin : g_lane
    assign dr[e][0]   = r0[e];
    assign dnq[e][0]  = nlo[e];
    assign ddv[e][0]  = dv0[e];
    assign dsat[e][0] = st0[e];
    for (genvar k = 0; k < QB; k++) begin : g_div
      ptd_div_cell #(.LW(LW)) u_cell (
        .clk(clk), .en(en),
        .r_i(dr[e][k]), .nq_i(dnq[e][k]), .dvs_i(ddv[e][k]), .sat_i(dsat[e][k]),
        .r_o(dr[e][k+1]), .nq_o(dnq[e][k+1]), .dvs_o(ddv[e][k+1]), .sat_o(dsat[e][k+1])
      );
    end
    assign qv[e] = dsat[e][QB] ? '1 : dnq[e][QB];
  end

  // least of the three clamped radicands
  always_comb begin
    qmin = qv[0];
    if (qv[1] < qmin) qmin = qv[1];
    if (qv[2] < qmin) qmin = qv[2];
  end

  always_ff @(posedge clk) begin
    if (en) qmin_r <= qmin;
  end

  // square root cell chain
  assign sx[0]    = qmin_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  for (genvar k = 0; k < OUT_W; k++) begin : g_sqrt
    ptd_sqrt_cell u_cell (
      .clk(clk), .en(en),
      .x_i(sx[k]), .rem_i(srem[k]), .root_i(sroot[k]),
      .x_o(sx[k+1]), .rem_o(srem[k+1]), .root_o(sroot[k+1])
    );
  end

  // output register: load from the last stage, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v_r[PIPE] && en) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v_r[PIPE] && en) begin
      out_inside_r <= ins_r[PIPE];
      out_dist_r   <= ins_r[PIPE] ? '0 : sroot[OUT_W];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_inside_res      = out_inside_r;
  assign out_distance_scaled = out_dist_r;

  `PTD_ASSERT_SAME(a_full_holds, clk, rst_n, v_r[PIPE] && out_valid_r && out_stall, in_stall)
  `PTD_ASSERT_SAME(a_inside_zero, clk, rst_n, out_valid && out_inside_res, out_distance_scaled == '0)
  `PTD_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, v_r[1])
  `PTD_ASSERT_NEXT(a_last_lands, clk, rst_n, v_r[PIPE] && !in_stall, out_valid)
endmodule

### rtl/ptd_edge.sv
// Front math for one edge: projection test, squared distance numerator, divide setup.
`timescale 1ns / 1ps
module ptd_edge #(
  parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH_DEF,
  parameter int DIST_SCALE  = ptd_pkg::DIST_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_WIDTH:0]       ax_i,
  input  logic signed [COORD_WIDTH:0]       ay_i,
  input  logic signed [COORD_WIDTH:0]       ex_i,
  input  logic signed [COORD_WIDTH:0]       ey_i,
  input  logic signed [COORD_WIDTH:0]       bx_i,
  input  logic signed [COORD_WIDTH:0]       by_i,
  output logic [ptd_pkg::QB-1:0]            nlo_o,
  output logic [2*COORD_WIDTH+2:0]          r0_o,
  output logic [2*COORD_WIDTH+2:0]          dvs_o,
  output logic                              sat_o
);
  import ptd_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = 2 * DW;
  localparam int LW  = PW + 1;
  localparam int MW  = 2 * LW;
  localparam int MH  = (MW + 1) / 2;
  localparam logic [63:0] S2 = 64'(DIST_SCALE) * 64'(DIST_SCALE);
  localparam int S2W = $clog2(S2 + 64'd1);
  localparam logic [S2W-1:0] S2V = S2[S2W-1:0];
  localparam int NA  = MW + S2W;
  localparam int NB  = QB + LW + 1;
  localparam int NX  = (NA > NB) ? NA : NB;

  // products
  logic signed [PW-1:0] axex_r, ayey_r, axey_r, ayex_r, exex_r, eyey_r;
  logic signed [PW-1:0] axax_r, ayay_r, bxbx_r, byby_r;
  // sums
  logic signed [LW-1:0] dot_r, crs_r;
  logic [LW-1:0]        len_r, d2a_r, d2b_r;
  // selection
  logic                 perp_r;
  logic [LW-1:0]        cabs_r, len4_r, d2s_r;
  logic [LW-1:0]        cabs_nxt, d2s_nxt;
  logic                 perp_nxt;
  // numerator
  logic [MW-1:0]        m_r;
  logic [LW-1:0]        dvs5_r, dvs6_r, dvs7_r;
  logic [MH+S2W-1:0]    pplo_r;
  logic [MW-MH+S2W-1:0] pphi_r;
  logic [NX-1:0]        n_r;

  // form all products of the edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      axex_r <= ax_i * ex_i;
      ayey_r <= ay_i * ey_i;
      axey_r <= ax_i * ey_i;
      ayex_r <= ay_i * ex_i;
      exex_r <= ex_i * ex_i;
      eyey_r <= ey_i * ey_i;
      axax_r <= ax_i * ax_i;
      ayay_r <= ay_i * ay_i;
      bxbx_r <= bx_i * bx_i;
      byby_r <= by_i * by_i;
    end
  end

  // dot, cross, squared lengths
  always_ff @(posedge clk) begin
    if (en) begin
      dot_r <= LW'(axex_r) + LW'(ayey_r);
      crs_r <= LW'(axey_r) - LW'(ayex_r);
      len_r <= LW'(exex_r) + LW'(eyey_r);
      d2a_r <= LW'(axax_r) + LW'(ayay_r);
      d2b_r <= LW'(bxbx_r) + LW'(byby_r);
    end
  end

  // clamp the projection to the segment
  always_comb begin
    perp_nxt = (len_r != '0) && (dot_r > 0) && (dot_r < $signed({1'b0, len_r}));
    cabs_nxt = (crs_r < 0) ? LW'(-crs_r) : LW'(crs_r);
    if (len_r == '0 || dot_r <= 0) begin
      d2s_nxt = d2a_r;
    end else if (dot_r >= $signed({1'b0, len_r})) begin
      d2s_nxt = d2b_r;
    end else begin
      d2s_nxt = d2a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      perp_r <= perp_nxt;
      cabs_r <= cabs_nxt;
      len4_r <= len_r;
      d2s_r  <= d2s_nxt;
    end
  end

  // squared distance numerator and divisor
  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= perp_r ? cabs_r * cabs_r : MW'(d2s_r);
      dvs5_r <= perp_r ? len4_r : LW'(1);
    end
  end

  // scale by DIST_SCALE squared in two partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pplo_r <= m_r[MH-1:0] * S2V;
      pphi_r <= m_r[MW-1:MH] * S2V;
      dvs6_r <= dvs5_r;
      n_r    <= NX'(pplo_r) + (NX'(pphi_r) << MH);
      dvs7_r <= dvs6_r;
    end
  end

  // split off the divide's leading remainder; flag quotients past the clamp
  always_ff @(posedge clk) begin
    if (en) begin
      sat_o <= n_r[NX-1:QB] >= (NX - QB)'(dvs7_r);
      r0_o  <= n_r[QB+LW-1:QB];
      nlo_o <= n_r[QB-1:0];
      dvs_o <= dvs7_r;
    end
  end
endmodule

### rtl/ptd_div_cell.sv
// One restoring divide step: one quotient bit per cell.
`timescale 1ns / 1ps
module ptd_div_cell #(
  parameter int LW = 35
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [LW-1:0]          r_i,
  input  logic [ptd_pkg::QB-1:0] nq_i,
  input  logic [LW-1:0]          dvs_i,
  input  logic                   sat_i,
  output logic [LW-1:0]          r_o,
  output logic [ptd_pkg::QB-1:0] nq_o,
  output logic [LW-1:0]          dvs_o,
  output logic                   sat_o
);
  import ptd_pkg::*;

  logic [LW:0]   t;
  logic          qbit;
  logic [LW-1:0] r_nxt;

  // shift in the next numerator bit, subtract when it fits
  always_comb begin
    t     = {r_i, nq_i[QB-1]};
    qbit  = t >= {1'b0, dvs_i};
    r_nxt = qbit ? LW'(t - {1'b0, dvs_i}) : t[LW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_o   <= r_nxt;
      nq_o  <= {nq_i[QB-2:0], qbit};
      dvs_o <= dvs_i;
      sat_o <= sat_i;
    end
  end
endmodule

### rtl/ptd_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per cell.
`timescale 1ns / 1ps
module ptd_sqrt_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ptd_pkg::QB-1:0]    x_i,
  input  logic [ptd_pkg::OUT_W+1:0] rem_i,
  input  logic [ptd_pkg::OUT_W-1:0] root_i,
  output logic [ptd_pkg::QB-1:0]    x_o,
  output logic [ptd_pkg::OUT_W+1:0] rem_o,
  output logic [ptd_pkg::OUT_W-1:0] root_o
);
  import ptd_pkg::*;

  logic [OUT_W+1:0] t, trial;
  logic             bit_ok;

  // bring down two radicand bits and try root*4+1
  always_comb begin
    t      = {rem_i[OUT_W-1:0], x_i[QB-1:QB-2]};
    trial  = {root_i, 2'b01};
    bit_ok = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o    <= {x_i[QB-3:0], 2'b00};
      rem_o  <= bit_ok ? t - trial : t;
      root_o <= {root_i[OUT_W-2:0], bit_ok};
    end
  end
endmodule
